### rtl/core/sfn_pkg.sv
`timescale 1ns / 1ps

package sfn_pkg;

  // default field sizes of the short name
  localparam int BASE_LEN_DEF = 8;
  localparam int EXT_LEN_DEF  = 3;

  // entries in the queue between the classifier and the name builder
  localparam int QUEUE_DEPTH = 2;

  // character codes
  localparam logic [7:0] SPACE_CHAR = 8'h20;
  localparam logic [7:0] DOT_CHAR   = 8'h2E;
  localparam logic [7:0] LOWER_A    = 8'h61;
  localparam logic [7:0] LOWER_Z    = 8'h7A;
  localparam logic [7:0] UPPER_A    = 8'h41;
  localparam logic [7:0] NUL_CHAR   = 8'h00;

  // width of the position field of a result
  localparam int POS_W = 4;

  // operation kinds handed from the classifier to the name builder
  typedef enum logic [1:0] {
    OP_CHAR = 2'd0,
    OP_DOT  = 2'd1,
    OP_END  = 2'd2
  } op_e;

  typedef struct packed {
    op_e        kind;
    logic [7:0] ch;
  } op_t;

  // builder states
  typedef enum logic [1:0] {
    ST_COLLECT = 2'b01,
    ST_EMIT    = 2'b10
  } state_e;

  // lower-case letters to upper case, everything else unchanged
  function automatic logic [7:0] to_upper(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if ((c >= LOWER_A) && (c <= LOWER_Z)) begin
      r = c - LOWER_A + UPPER_A;
    end
    return r;
  endfunction

endpackage

### rtl/core/sfn_stream_ifs.sv
`timescale 1ns / 1ps

// name byte channel
interface sfn_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;

  modport source (output valid, output char_byte, input ready);
  modport sink (input valid, input char_byte, output ready);
endinterface

// short name byte channel
interface sfn_name_if;
  logic                        valid;
  logic                        ready;
  logic [sfn_pkg::POS_W-1:0]   position;
  logic [7:0]                  out_byte;
  logic                        last_byte;

  modport source (output valid, output position, output out_byte, output last_byte,
                  input ready);
  modport sink (input valid, input position, input out_byte, input last_byte,
                output ready);
endinterface

### rtl/core/sfn_front.sv
`timescale 1ns / 1ps

module sfn_front (
  input  logic [7:0]   char_byte_i,
  output sfn_pkg::op_t op_o
);

  // classify the byte and fold lower case to upper case
  always_comb begin
    op_o.ch   = sfn_pkg::to_upper(char_byte_i);
    op_o.kind = sfn_pkg::OP_CHAR;
    if (char_byte_i == sfn_pkg::NUL_CHAR) begin
      op_o.kind = sfn_pkg::OP_END;
    end else if (char_byte_i == sfn_pkg::DOT_CHAR) begin
      op_o.kind = sfn_pkg::OP_DOT;
    end
  end

endmodule

### rtl/core/sfn_queue.sv
`timescale 1ns / 1ps

module sfn_queue (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  sfn_pkg::op_t push_op_i,
  output logic         full_o,
  input  logic         pop_i,
  output logic         valid_o,
  output sfn_pkg::op_t pop_op_o
);

  localparam int Depth = sfn_pkg::QUEUE_DEPTH;
  localparam int PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW  = $clog2(Depth + 1);

  sfn_pkg::op_t    entry_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push, do_pop;

  assign full_o   = (count_q == CntW'(Depth));
  assign valid_o  = (count_q != '0);
  assign pop_op_o = entry_q[rd_ptr_q];
  assign do_push  = push_i && !full_o;
  assign do_pop   = pop_i && valid_o;

  // pointer and fill bookkeeping
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_op_i;
    end
  end

endmodule

### rtl/core/sfn_back.sv
`timescale 1ns / 1ps

module sfn_back #(
  parameter int BASE_LEN = sfn_pkg::BASE_LEN_DEF,
  parameter int EXT_LEN  = sfn_pkg::EXT_LEN_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      op_valid_i,
  input  sfn_pkg::op_t              op_i,
  output logic                      op_pop_o,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [sfn_pkg::POS_W-1:0] position_o,
  output logic [7:0]                out_byte_o,
  output logic                      last_byte_o
);

  localparam int Total = BASE_LEN + EXT_LEN;
  localparam int IdxW  = $clog2(Total);
  localparam int BiW   = (BASE_LEN > 1) ? $clog2(BASE_LEN) : 1;
  localparam int EiW   = (EXT_LEN > 1) ? $clog2(EXT_LEN) : 1;
  localparam int BcW   = $clog2(BASE_LEN + 1);
  localparam int EcW   = $clog2(EXT_LEN + 1);

  logic [7:0]     base_store_q [BASE_LEN];
  logic [7:0]     ext_store_q  [EXT_LEN];
  logic [BcW-1:0] base_count_q, base_count_d;
  logic [EcW-1:0] ext_count_q, ext_count_d;
  logic           base_closed_q, base_closed_d;
  logic [IdxW-1:0] idx_q, idx_d;
  sfn_pkg::state_e state_q, state_d;

  logic           out_valid_q, out_valid_d;
  logic [sfn_pkg::POS_W-1:0] position_q;
  logic [7:0]     out_byte_q;
  logic           last_byte_q;

  logic           out_free;
  logic           load_out;
  logic [IdxW-1:0] sel_idx;
  logic [IdxW+sfn_pkg::POS_W-1:0] pos_wide;
  logic [IdxW-1:0] ext_off;
  logic [7:0]     sel_byte;
  logic           sel_last;
  logic           base_wr, ext_wr;

  assign out_free = !out_valid_q || out_ready_i;

  // byte of the short name at the selected index, space where nothing was kept
  always_comb begin
    ext_off  = sel_idx - IdxW'(BASE_LEN);
    sel_byte = sfn_pkg::SPACE_CHAR;
    if (32'(sel_idx) < BASE_LEN) begin
      if (32'(sel_idx) < 32'(base_count_q)) begin
        sel_byte = base_store_q[sel_idx[BiW-1:0]];
      end
    end else if (32'(ext_off) < 32'(ext_count_q)) begin
      sel_byte = ext_store_q[ext_off[EiW-1:0]];
    end
    sel_last = (sel_idx == IdxW'(Total - 1));
    pos_wide = {{sfn_pkg::POS_W{1'b0}}, sel_idx};
  end

  // collect and emit control
  always_comb begin
    state_d       = state_q;
    idx_d         = idx_q;
    base_count_d  = base_count_q;
    ext_count_d   = ext_count_q;
    base_closed_d = base_closed_q;
    op_pop_o      = 1'b0;
    load_out      = 1'b0;
    sel_idx       = idx_q;
    base_wr       = 1'b0;
    ext_wr        = 1'b0;
    case (state_q)
      sfn_pkg::ST_COLLECT: begin
        sel_idx = '0;
        if (op_valid_i) begin
          case (op_i.kind)
            sfn_pkg::OP_END: begin
              if (out_free) begin
                op_pop_o = 1'b1;
                load_out = 1'b1;
                idx_d    = IdxW'(1);
                state_d  = sfn_pkg::ST_EMIT;
              end
            end
            sfn_pkg::OP_DOT: begin
              op_pop_o      = 1'b1;
              base_closed_d = 1'b1;
              ext_count_d   = '0;
            end
            sfn_pkg::OP_CHAR: begin
              op_pop_o = 1'b1;
              if (!base_closed_q) begin
                if (32'(base_count_q) < BASE_LEN) begin
                  base_wr      = 1'b1;
                  base_count_d = base_count_q + 1'b1;
                end
              end else if (32'(ext_count_q) < EXT_LEN) begin
                ext_wr      = 1'b1;
                ext_count_d = ext_count_q + 1'b1;
              end
            end
            default: begin
              op_pop_o = 1'b1;
            end
          endcase
        end
      end
      sfn_pkg::ST_EMIT: begin
        if (out_free) begin
          load_out = 1'b1;
          if (sel_last) begin
            // name done, back to the empty state
            idx_d         = '0;
            base_count_d  = '0;
            ext_count_d   = '0;
            base_closed_d = 1'b0;
            state_d       = sfn_pkg::ST_COLLECT;
          end else begin
            idx_d = idx_q + 1'b1;
          end
        end
      end
      default: begin
        state_d = sfn_pkg::ST_COLLECT;
      end
    endcase
  end

  // output register valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= sfn_pkg::ST_COLLECT;
      idx_q         <= '0;
      base_count_q  <= '0;
      ext_count_q   <= '0;
      base_closed_q <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      idx_q         <= idx_d;
      base_count_q  <= base_count_d;
      ext_count_q   <= ext_count_d;
      base_closed_q <= base_closed_d;
      out_valid_q   <= out_valid_d;
    end
  end

  // character stores, read only below their fill counts
  always_ff @(posedge clk_i) begin
    if (base_wr) begin
      base_store_q[base_count_q[BiW-1:0]] <= op_i.ch;
    end
    if (ext_wr) begin
      ext_store_q[ext_count_q[EiW-1:0]] <= op_i.ch;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (load_out) begin
      position_q  <= pos_wide[sfn_pkg::POS_W-1:0];
      out_byte_q  <= sel_byte;
      last_byte_q <= sel_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign position_o  = position_q;
  assign out_byte_o  = out_byte_q;
  assign last_byte_o = last_byte_q;

endmodule

### rtl/core/short_name_formatter.sv
`timescale 1ns / 1ps

// Short name formatter: takes one file-name byte per request on char_i and builds an
// 8.3 style short name (base field of BASE_LEN bytes, extension of EXT_LEN bytes,
// upper-cased, space padded). Name bytes are taken one per cycle while the queue has
// room and give no result; a zero byte ends the name and the block then sends
// BASE_LEN + EXT_LEN requests on name_o, one per cycle while name_o is ready, with
// last_byte set on the final one. While a name is sent out, a two-entry queue behind
// the input keeps taking the next name's bytes, so input stalls only once it fills.

module short_name_formatter #(
  parameter int BASE_LEN = sfn_pkg::BASE_LEN_DEF,
  parameter int EXT_LEN  = sfn_pkg::EXT_LEN_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  sfn_char_if.sink   char_i,
  sfn_name_if.source name_o
);

  sfn_pkg::op_t cls_op;
  sfn_pkg::op_t q_op;
  logic         q_full;
  logic         q_valid;
  logic         q_pop;

  // classify incoming bytes
  sfn_front u_front (
    .char_byte_i (char_i.char_byte),
    .op_o        (cls_op)
  );

  assign char_i.ready = !q_full;

  // decoupling queue
  sfn_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (char_i.valid),
    .push_op_i (cls_op),
    .full_o    (q_full),
    .pop_i     (q_pop),
    .valid_o   (q_valid),
    .pop_op_o  (q_op)
  );

  // name builder and output
  sfn_back #(
    .BASE_LEN (BASE_LEN),
    .EXT_LEN  (EXT_LEN)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_valid_i  (q_valid),
    .op_i        (q_op),
    .op_pop_o    (q_pop),
    .out_valid_o (name_o.valid),
    .out_ready_i (name_o.ready),
    .position_o  (name_o.position),
    .out_byte_o  (name_o.out_byte),
    .last_byte_o (name_o.last_byte)
  );

endmodule

### tb/short_name_formatter_test.sv
`timescale 1ns / 1ps

module short_name_formatter_test;

  localparam int BASE_N = sfn_pkg::BASE_LEN_DEF;
  localparam int EXT_N = sfn_pkg::EXT_LEN_DEF;
  localparam int NAME_W = BASE_N + EXT_N;
  localparam int DIR_N = 24;
  localparam int HOLD_CYCLES = 150;
  localparam int IDLE_LIMIT = 4000;
  localparam int PHASE_BYTES = 18;

  // one directed row: a name byte, and for a zero byte optionally the short name typed in
  typedef struct packed {
    logic [7:0]          ch;
    logic                fixed;
    logic [NAME_W*8-1:0] short_name;
  } name_byte_row_t;

  // one expected byte of a short name
  typedef struct packed {
    logic [sfn_pkg::POS_W-1:0] pos;
    logic [7:0]                ch;
    logic                      last;
  } short_byte_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  // tb-side drivers, known from time zero
  logic                snd_valid = 1'b0;
  logic [7:0]          snd_byte = sfn_pkg::NUL_CHAR;
  logic                snd_fixed = 1'b0;
  logic [NAME_W*8-1:0] snd_short_name = '0;
  logic                rcv_ready = 1'b0;

  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_seq = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int idle_cycles = 0;
  int err_cnt = 0;

  // name being built, as the block should see it
  logic [7:0] nm_base [BASE_N];
  logic [7:0] nm_ext [EXT_N];
  int         nm_base_cnt = 0;
  int         nm_ext_cnt = 0;
  logic       nm_in_ext = 1'b0;

  short_byte_t short_name_q [$];

  name_byte_row_t dir_tbl [DIR_N];

  sfn_char_if char_if ();
  sfn_name_if name_if ();

  assign char_if.valid = snd_valid;
  assign char_if.char_byte = snd_byte;
  assign name_if.ready = rcv_ready;

  short_name_formatter dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .char_i (char_if),
    .name_o (name_if)
  );

  always #4 clk_i = ~clk_i;

  // clear the name under construction
  function automatic void clear_name();
    int k;
    for (k = 0; k < BASE_N; k++) nm_base[k] = sfn_pkg::SPACE_CHAR;
    for (k = 0; k < EXT_N; k++) nm_ext[k] = sfn_pkg::SPACE_CHAR;
    nm_base_cnt = 0;
    nm_ext_cnt = 0;
    nm_in_ext = 1'b0;
  endfunction

  // fold one accepted byte into the name; a zero byte queues the short name
  function automatic void fold_char(input logic [7:0] c, input logic fixed,
                                    input logic [NAME_W*8-1:0] short_name);
    short_byte_t sb;
    logic [7:0]  up;
    int          k;
    up = c;
    if ((c >= sfn_pkg::LOWER_A) && (c <= sfn_pkg::LOWER_Z)) begin
      up = c - sfn_pkg::LOWER_A + sfn_pkg::UPPER_A;
    end
    if (c == sfn_pkg::DOT_CHAR) begin
      // every dot restarts the extension
      nm_in_ext = 1'b1;
      for (k = 0; k < EXT_N; k++) nm_ext[k] = sfn_pkg::SPACE_CHAR;
      nm_ext_cnt = 0;
    end else if (c != sfn_pkg::NUL_CHAR) begin
      if (!nm_in_ext) begin
        if (nm_base_cnt < BASE_N) begin
          nm_base[nm_base_cnt] = up;
          nm_base_cnt++;
        end
      end else if (nm_ext_cnt < EXT_N) begin
        nm_ext[nm_ext_cnt] = up;
        nm_ext_cnt++;
      end
    end else begin
      for (k = 0; k < NAME_W; k++) begin
        sb.pos = sfn_pkg::POS_W'(k);
        if (fixed) begin
          sb.ch = short_name[NAME_W*8-1-8*k -: 8];
        end else if (k < BASE_N) begin
          sb.ch = nm_base[k];
        end else begin
          sb.ch = nm_ext[k-BASE_N];
        end
        sb.last = (k == NAME_W - 1);
        short_name_q.push_back(sb);
      end
      clear_name();
    end
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    err_cnt++;
  endtask

  // prediction, checking and watchdog, all sampled at the clock edge
  always @(posedge clk_i) begin
    short_byte_t want;
    if (rst_ni) begin
      if (char_if.valid && char_if.ready) begin
        fold_char(char_if.char_byte, snd_fixed, snd_short_name);
      end
      if (name_if.valid && name_if.ready) begin
        if (short_name_q.size() == 0) begin
          report_mismatch("unexpected request", name_if.out_byte, 0);
        end else begin
          want = short_name_q.pop_front();
          if (name_if.position !== want.pos)
            report_mismatch("position", name_if.position, want.pos);
          if (name_if.out_byte !== want.ch)
            report_mismatch("out_byte", name_if.out_byte, want.ch);
          if (name_if.last_byte !== want.last)
            report_mismatch("last_byte", name_if.last_byte, want.last);
        end
      end
      if ((char_if.valid && char_if.ready) || (name_if.valid && name_if.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout: no request moved for %0d cycles", IDLE_LIMIT);
        $display("FAIL short_name_formatter");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // receiver: random stalls, plus a long hold-off when asked for
  always @(posedge clk_i) begin
    if (hold_seq != hold_seen) begin
      hold_seen <= hold_seq;
      hold_left <= HOLD_CYCLES;
      rcv_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      rcv_ready <= 1'b0;
    end else begin
      rcv_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // offer one name byte and wait for it to be taken
  task automatic send_byte(input logic [7:0] b, input logic fixed,
                           input logic [NAME_W*8-1:0] short_name);
    while ($urandom_range(99) < send_idle_pct) begin
      snd_valid <= 1'b0;
      @(posedge clk_i);
    end
    snd_valid <= 1'b1;
    snd_byte <= b;
    snd_fixed <= fixed;
    snd_short_name <= short_name;
    @(posedge clk_i);
    while (!char_if.ready) @(posedge clk_i);
  endtask

  function automatic logic [7:0] rand_name_char(input logic allow_dot);
    int         r;
    logic [7:0] c;
    r = $urandom_range(99);
    if (r < 55) c = sfn_pkg::LOWER_A + 8'($urandom_range(25));
    else if (allow_dot && (r < 68)) c = sfn_pkg::DOT_CHAR;
    else if (r < 80) c = sfn_pkg::UPPER_A + 8'($urandom_range(25));
    else c = 8'($urandom_range(255, 1));
    return c;
  endfunction

  // one random name with its terminator; half are plain base.ext shapes
  task automatic send_name(output int n);
    int len;
    int k;
    n = 0;
    if ($urandom_range(1) == 0) begin
      len = $urandom_range(11);
      for (k = 0; k < len; k++) send_byte(rand_name_char(1'b0), 1'b0, '0);
      send_byte(sfn_pkg::DOT_CHAR, 1'b0, '0);
      n = len + 1;
      len = $urandom_range(5);
      for (k = 0; k < len; k++) send_byte(rand_name_char(1'b0), 1'b0, '0);
      n += len;
    end else begin
      len = ($urandom_range(9) == 0) ? $urandom_range(20, 14) : $urandom_range(12);
      for (k = 0; k < len; k++) send_byte(rand_name_char(1'b1), 1'b0, '0);
      n = len;
    end
    send_byte(sfn_pkg::NUL_CHAR, 1'b0, '0);
    n++;
  endtask

  // stop offering and wait until every short name byte has come back
  task automatic drain();
    snd_valid <= 1'b0;
    @(posedge clk_i);
    while (short_name_q.size() != 0) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  initial begin
    int idle_of [4];
    int stall_of [4];
    int p;
    int i;
    int sent;
    int n;
    idle_of = '{0, 70, 0, 28};
    stall_of = '{0, 0, 70, 28};
    clear_name();

    // empty name, several dots with an overlong extension, leading dot with
    // bytes next to the letter range, overlong base with high and low bytes
    dir_tbl = '{
      '{sfn_pkg::NUL_CHAR, 1'b1, "           "},
      '{"a", 1'b0, '0}, '{sfn_pkg::DOT_CHAR, 1'b0, '0}, '{"b", 1'b0, '0},
      '{sfn_pkg::DOT_CHAR, 1'b0, '0}, '{"c", 1'b0, '0}, '{"d", 1'b0, '0},
      '{"e", 1'b0, '0}, '{"z", 1'b0, '0},
      '{sfn_pkg::NUL_CHAR, 1'b1, "A       CDE"},
      '{sfn_pkg::DOT_CHAR, 1'b0, '0}, '{8'h60, 1'b0, '0}, '{8'h7B, 1'b0, '0},
      '{sfn_pkg::NUL_CHAR, 1'b0, '0},
      '{"z", 1'b0, '0}, '{8'hFF, 1'b0, '0}, '{8'h80, 1'b0, '0},
      '{8'h01, 1'b0, '0}, '{"A", 1'b0, '0}, '{8'h40, 1'b0, '0},
      '{8'h5B, 1'b0, '0}, '{"m", 1'b0, '0}, '{"q", 1'b0, '0},
      '{sfn_pkg::NUL_CHAR, 1'b0, '0}
    };

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed names
    for (i = 0; i < DIR_N; i++) begin
      send_byte(dir_tbl[i].ch, dir_tbl[i].fixed, dir_tbl[i].short_name);
    end
    drain();

    // random names under each idling mix
    for (p = 0; p < 4; p++) begin
      send_idle_pct = idle_of[p];
      stall_pct <= stall_of[p];
      // long receiver hold-off while names keep coming at full rate
      if (p == 0) hold_seq <= hold_seq + 1;
      sent = 0;
      while (sent < PHASE_BYTES) begin
        send_name(n);
        sent += n;
      end
      drain();
    end

    repeat (30) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("PASS short_name_formatter");
    end else begin
      $display("FAIL short_name_formatter");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/core/sfn_pkg.sv
rtl/core/sfn_stream_ifs.sv
rtl/core/sfn_front.sv
rtl/core/sfn_queue.sv
rtl/core/sfn_back.sv
rtl/core/short_name_formatter.sv
tb/short_name_formatter_test.sv
